// File: rtl/lru_pr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared types and fixed widths for the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

   localparam int CSR_W       = 5;
   localparam int PORT_PAGE_W = 16;
   localparam int COUNT_W     = 32;

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(16);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // broadcast from the top level to every cell in the recency chain
   typedef struct packed {
      logic step;   // a word is accepted this cycle
      logic start;  // empty the chain before handling the word
      logic hit;    // requested page found somewhere in the chain
      logic evict;  // chain is at capacity, the oldest entry drops out
   } cell_ctl_type;

endpackage

// File: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit built as a chain of recency cells; slot 0 holds
// the most recent page, the valid slots always form a prefix of the chain.
// ----------------------------------------------------------------------------
// The response word sits in an output register, valid in the next cycle.
// Throughput: one word per cycle unless rsp_ready stalls the output; the compare
//   across all cells and the chain shift happen in the accepting cycle.
// Reset: chain empty, hit and miss counts zero, capacity register at 16.
// ----------------------------------------------------------------------------
module lru_page_replacement
   import lru_pr_pkg::*;
#(
   parameter int MEM_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PORT_PAGE_W-1:0] req_page_number,
   input  logic                   req_start_run,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic                   rsp_evicted_valid,
   output logic [PORT_PAGE_W-1:0] rsp_evicted_page,
   output logic [COUNT_W-1:0]     rsp_hit_count,
   output logic [COUNT_W-1:0]     rsp_miss_count,
   input  logic                   csr_write_enable,
   input  logic [CSR_W-1:0]       csr_write_data
);

   localparam int CNT_W = $clog2(MEM_FRAMES + 1);
   localparam int CMP_W = CNT_W + CSR_W;
   localparam logic [CMP_W-1:0] FRAMES_MAX = CMP_W'(MEM_FRAMES);

   logic [CSR_W-1:0]     csr_pages_ff;
   logic [CNT_W-1:0]     count_ff, count_in, count_eff;
   logic [COUNT_W-1:0]   hits_ff, hits_in, hits_eff;
   logic [COUNT_W-1:0]   misses_ff, misses_in, misses_eff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic                 rsp_ev_valid_ff;
   logic [PORT_PAGE_W-1:0] rsp_ev_page_ff, ev_page_port;

   logic                 accept;
   logic [PAGE_BITS-1:0] req_page;
   logic [CMP_W-1:0]     capacity;
   logic [PAGE_BITS-1:0] ev_page;
   cell_ctl_type         ctl;

   logic [PAGE_BITS-1:0] cell_page  [MEM_FRAMES];
   logic                 cell_valid [MEM_FRAMES];
   logic                 cell_chain [MEM_FRAMES];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   generate
      if (PAGE_BITS >= PORT_PAGE_W) begin : g_wide_page
         assign req_page     = PAGE_BITS'(req_page_number);
         assign ev_page_port = ev_page[PORT_PAGE_W-1:0];
      end else begin : g_narrow_page
         assign req_page     = req_page_number[PAGE_BITS-1:0];
         assign ev_page_port = PORT_PAGE_W'(ev_page);
      end
   endgenerate

   // capacity clamped to 1..MEM_FRAMES
   always_comb begin
      capacity = CMP_W'(csr_pages_ff);
      if (csr_pages_ff == '0) begin
         capacity = CMP_W'(1);
      end else if (capacity > FRAMES_MAX) begin
         capacity = FRAMES_MAX;
      end
   end

   assign count_eff  = req_start_run ? '0 : count_ff;
   assign hits_eff   = req_start_run ? '0 : hits_ff;
   assign misses_eff = req_start_run ? '0 : misses_ff;

   assign ctl.step  = accept;
   assign ctl.start = req_start_run;
   assign ctl.hit   = cell_chain[0];
   assign ctl.evict = CMP_W'(count_eff) >= capacity;

   generate
      for (genvar i = 0; i < MEM_FRAMES; i++) begin : g_cell
         logic [PAGE_BITS-1:0] left_page;
         logic                 left_valid;
         logic                 hit_right;
         if (i == 0) begin : g_head
            assign left_page  = req_page;
            assign left_valid = 1'b1;
         end else begin : g_body
            assign left_page  = cell_page[i-1];
            assign left_valid = cell_valid[i-1];
         end
         if (i == MEM_FRAMES - 1) begin : g_tail
            assign hit_right = 1'b0;
         end else begin : g_inner
            assign hit_right = cell_chain[i+1];
         end
         lru_pr_cell #(
            .PAGE_BITS(PAGE_BITS)
         ) u_cell (
            .clock            (clock),
            .reset            (reset),
            .ctl              (ctl),
            .req_page         (req_page),
            .left_page        (left_page),
            .left_valid       (left_valid),
            .hit_right        (hit_right),
            .page             (cell_page[i]),
            .valid            (cell_valid[i]),
            .hit_here_or_right(cell_chain[i])
         );
      end
   endgenerate

   // oldest page sits in the last valid slot
   always_comb begin
      ev_page = '0;
      for (int i = 0; i < MEM_FRAMES; i++) begin
         if (i == MEM_FRAMES - 1) begin
            if (cell_valid[i]) begin
               ev_page = ev_page | cell_page[i];
            end
         end else if (cell_valid[i] && !cell_valid[i+1]) begin
            ev_page = ev_page | cell_page[i];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if (accept) begin
         count_in  = count_eff;
         hits_in   = hits_eff;
         misses_in = misses_eff;
         if (ctl.hit) begin
            if (hits_eff != COUNT_MAX) begin
               hits_in = hits_eff + COUNT_W'(1);
            end
         end else begin
            if (!ctl.evict) begin
               count_in = count_eff + CNT_W'(1);
            end
            if (misses_eff != COUNT_MAX) begin
               misses_in = misses_eff + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_pages_ff <= CSR_RESET;
         count_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_pages_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff      <= ctl.hit;
         rsp_ev_valid_ff <= ~ctl.hit & ctl.evict;
         rsp_ev_page_ff  <= (~ctl.hit & ctl.evict) ? ev_page_port : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_hit_count     = hits_ff;
   assign rsp_miss_count    = misses_ff;

endmodule

// File: rtl/lru_pr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pr_cell
// One slot of the recency chain. Holds a page and a valid bit, compares
// against the request and takes its left neighbor's page when the chain shifts.
// ----------------------------------------------------------------------------
module lru_pr_cell
   import lru_pr_pkg::*;
#(
   parameter int PAGE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [PAGE_BITS-1:0] req_page,
   input  logic [PAGE_BITS-1:0] left_page,
   input  logic                 left_valid,
   input  logic                 hit_right,
   output logic [PAGE_BITS-1:0] page,
   output logic                 valid,
   output logic                 hit_here_or_right
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic                 valid_in;
   logic                 match;
   logic                 shift;

   // a start flag makes the chain look empty for this word
   assign valid = valid_ff & ~ctl.start;
   assign page  = page_ff;

   assign match             = valid && (page_ff == req_page);
   assign hit_here_or_right = match | hit_right;

   // hit: every slot up to the matching one moves down by one
   // miss: every valid slot moves, plus the first free one unless evicting
   assign shift = ctl.hit ? hit_here_or_right : (valid | (~ctl.evict & left_valid));

   always_comb begin
      valid_in = valid_ff;
      if (ctl.step) begin
         valid_in = shift | valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step && shift) begin
         page_ff <= left_page;
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU page replacement unit. A frame tracker
// mirrors residency, recency and the hit/miss counts for every accepted
// request word and checks each response word in order. Stimulus is a short
// directed pass (capacity edges, promotion on hit, eviction order, run
// restart), then random phases over several capacities with page pools sized
// near the capacity. Both handshakes idle at random, and there is one long
// response stall and one full drain in mid-run.
// ----------------------------------------------------------------------------
module tb_top;
   import lru_pr_pkg::*;

   localparam int FRAMES      = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 90;
   localparam int IDLE_PCT    = 12;

   typedef struct packed {
      logic                   hit;
      logic                   evicted_valid;
      logic [PORT_PAGE_W-1:0] evicted_page;
      logic [COUNT_W-1:0]     hit_count;
      logic [COUNT_W-1:0]     miss_count;
   } page_result_type;

   // tracks frame residency and recency, queues the expected response words
   class lru_frame_tracker_type;
      logic [PORT_PAGE_W-1:0] frame_pg[FRAMES];
      bit                     frame_vld[FRAMES];
      int unsigned            frame_age[FRAMES];
      int unsigned            resident;
      logic [COUNT_W-1:0]     hit_total;
      logic [COUNT_W-1:0]     miss_total;
      logic [CSR_W-1:0]       cap_reg;
      page_result_type        expected_q[$];
      int                     errors;

      function new();
         clear_frames();
         hit_total  = '0;
         miss_total = '0;
         cap_reg    = CSR_RESET;
         errors     = 0;
      endfunction

      function void clear_frames();
         for (int i = 0; i < FRAMES; i++) begin
            frame_vld[i] = 1'b0;
            frame_age[i] = 0;
         end
         resident = 0;
      endfunction

      function void set_capacity(logic [CSR_W-1:0] value);
         cap_reg = value;
      endfunction

      function int unsigned capacity();
         if (cap_reg == 0)
            return 1;
         if (cap_reg > FRAMES)
            return FRAMES;
         return cap_reg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void age_frames(int unsigned limit);
         for (int i = 0; i < FRAMES; i++)
            if (frame_vld[i] && frame_age[i] < limit)
               frame_age[i]++;
      endfunction

      function void note_request(logic [PORT_PAGE_W-1:0] page, logic start);
         page_result_type res;
         int              found;
         int              slot;
         int unsigned     oldest;
         res   = '0;
         found = -1;
         slot  = -1;
         if (start) begin
            clear_frames();
            hit_total  = '0;
            miss_total = '0;
         end
         for (int i = 0; i < FRAMES; i++)
            if (found < 0 && frame_vld[i] && frame_pg[i] == page)
               found = i;
         if (found >= 0) begin
            res.hit = 1'b1;
            age_frames(frame_age[found]);
            frame_age[found] = 0;
            if (hit_total != COUNT_MAX)
               hit_total++;
         end else begin
            if (resident < capacity())
               for (int i = 0; i < FRAMES; i++)
                  if (slot < 0 && !frame_vld[i])
                     slot = i;
            if (slot < 0) begin
               // full (or over a lowered capacity): drop exactly one, the oldest
               oldest = 0;
               for (int i = 0; i < FRAMES; i++)
                  if (frame_vld[i] && (slot < 0 || frame_age[i] > oldest)) begin
                     slot   = i;
                     oldest = frame_age[i];
                  end
               if (slot >= 0) begin
                  res.evicted_valid = 1'b1;
                  res.evicted_page  = frame_pg[slot];
                  frame_vld[slot]   = 1'b0;
                  resident--;
               end else begin
                  slot = 0;
               end
            end
            age_frames('1);
            frame_pg[slot]  = page;
            frame_vld[slot] = 1'b1;
            frame_age[slot] = 0;
            resident++;
            if (miss_total != COUNT_MAX)
               miss_total++;
         end
         res.hit_count  = hit_total;
         res.miss_count = miss_total;
         expected_q.insert(expected_q.size(), res);
      endfunction

      task report_mismatch(string what, logic [COUNT_W-1:0] got_val,
                           logic [COUNT_W-1:0] want_val);
         errors++;
         $display("%0t MISMATCH %s: got 0x%0h expected 0x%0h",
                  $realtime, what, got_val, want_val);
      endtask

      task check_response(page_result_type got);
         page_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("response word with no request pending", 1, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit)
            report_mismatch("hit", got.hit, want.hit);
         if (got.evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
         if (got.evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
         if (got.hit_count !== want.hit_count)
            report_mismatch("hit_count", got.hit_count, want.hit_count);
         if (got.miss_count !== want.miss_count)
            report_mismatch("miss_count", got.miss_count, want.miss_count);
      endtask
   endclass

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [PORT_PAGE_W-1:0] req_page_number   = '0;
   logic                   req_start_run     = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic                   rsp_hit;
   logic                   rsp_evicted_valid;
   logic [PORT_PAGE_W-1:0] rsp_evicted_page;
   logic [COUNT_W-1:0]     rsp_hit_count;
   logic [COUNT_W-1:0]     rsp_miss_count;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_W-1:0]       csr_write_data    = '0;

   lru_frame_tracker_type board = new();

   bit tx_quiet    = 1'b0;
   bit rx_quiet    = 1'b0;
   bit rx_hold_req = 1'b0;
   int cycle_count = 0;

   lru_page_replacement #(
      .MEM_FRAMES (FRAMES),
      .PAGE_BITS  (PORT_PAGE_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .req_start_run     (req_start_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_miss_count    (rsp_miss_count),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // word accepted on either channel at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_page_number, req_start_run);
         if (rsp_valid && rsp_ready)
            board.check_response({rsp_hit, rsp_evicted_valid, rsp_evicted_page,
                                  rsp_hit_count, rsp_miss_count});
      end
   end

   // response side: random back-pressure, plus a long hold when asked
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            hold_left   = 60;
            rx_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= rx_quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_request(input logic [PORT_PAGE_W-1:0] page, input logic start);
      if (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      req_start_run   <= start;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_capacity(value);
   endtask

   initial begin
      int unsigned            cap_plan[12];
      int unsigned            eff;
      logic [PORT_PAGE_W-1:0] page_pool[$];
      logic [PORT_PAGE_W-1:0] page;
      logic                   start;
      cap_plan = '{16, 1, 2, 4, 8, 0, 31, 5, 17, 12, 3, 16};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: first words, hit on both page extremes
      send_request(16'h0000, 1'b1);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      drain_responses();
      // zero acts as one; two pages resident, so each miss without a run start evicts the oldest
      write_capacity(5'd0);
      send_request(16'h1234, 1'b0);
      send_request(16'h5555, 1'b0);
      send_request(16'hAAAA, 1'b1);
      send_request(16'h5555, 1'b0);
      drain_responses();
      write_capacity(5'd31);
      drain_responses();
      // three frames: promotion on hit changes the victim
      write_capacity(5'd3);
      send_request(16'h0101, 1'b1);
      send_request(16'h0202, 1'b0);
      send_request(16'h0303, 1'b0);
      send_request(16'h0101, 1'b0);
      send_request(16'h0404, 1'b0);
      send_request(16'h0202, 1'b0);
      send_request(16'h0101, 1'b0);
      send_request(16'h0303, 1'b0);
      drain_responses();
      // above the frame count acts as the frame count
      write_capacity(5'd17);
      send_request(16'h7FFF, 1'b0);
      send_request(16'hFEDC, 1'b1);
      send_request(16'h8000, 1'b0);

      for (int p = 0; p < 12; p++) begin
         drain_responses();
         write_capacity(CSR_W'(cap_plan[p]));
         tx_quiet = (p == 3);
         rx_quiet = (p == 3);
         eff = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > FRAMES ? FRAMES : cap_plan[p]);
         page_pool.delete();
         repeat (eff + $urandom_range(1, eff + 3))
            page_pool.insert(page_pool.size(), PORT_PAGE_W'($urandom_range(0, 65535)));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 6 && n == 30)
               rx_hold_req = 1'b1;
            if (p == 8 && n == 45)
               drain_responses();
            start = (n == 0 && p % 3 == 0) || ($urandom_range(99) < 2);
            if ($urandom_range(99) < 88)
               page = page_pool[$urandom_range(page_pool.size() - 1)];
            else
               page = PORT_PAGE_W'($urandom_range(0, 65535));
            send_request(page, start);
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;

      drain_responses();
      repeat (5) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
